>>> sv/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared constants, angle table and degree conversion for the tilt filter
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int ZW        = 27;
    localparam int STEP_W    = 5;
    localparam int ATAN_N    = 20;
    localparam int DEG_FRAC  = 16;
    localparam int DEG_W     = 10;
    localparam int ROLL_W    = 9;
    localparam int PITCH_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE = 1'b1;

    // atan(2^-i) in degrees, Q.16
    localparam logic [21:0] ATAN_TAB [0:ATAN_N-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57,      22'd29,     22'd14,     22'd7
    };

    localparam logic signed [ZW-1:0] Z_90  = 27'sd5898240;
    localparam logic signed [ZW-1:0] Z_180 = 27'sd11796480;

    localparam logic [DEG_W-2:0] ROLL_LIM  = 9'd180;
    localparam logic [DEG_W-2:0] PITCH_LIM = 9'd90;

    // Q.16 degrees to whole degrees, truncated toward zero and clamped
    function automatic logic signed [DEG_W-1:0] whole_deg(
        input logic signed [ZW-1:0] z,
        input logic [DEG_W-2:0]     lim
    );
        logic [ZW-1:0]          mag;
        logic [ZW-DEG_FRAC-1:0] d;
        logic [DEG_W-2:0]       c;
        logic signed [DEG_W-1:0] res;
        mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
        d   = mag[ZW-1:DEG_FRAC];
        c   = (d > (ZW-DEG_FRAC)'(lim)) ? lim : d[DEG_W-2:0];
        res = {1'b0, c};
        return z[ZW-1] ? -res : res;
    endfunction

endpackage

>>> sv/atl_sqrt.sv
// ----------------------------------------------------------------------------
// atl_sqrt
// Iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module atl_sqrt #(
    parameter int ROOT_W = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic                  o_busy,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic [2*ROOT_W-1:0] r_rad;
    logic [ROOT_W:0]     r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;

    logic [ROOT_W+2:0]   shifted;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                ge;
    logic [ROOT_W:0]     n_rem;
    logic [ROOT_W-1:0]   n_root;

    always_comb begin
        shifted = {r_rem, r_rad[2*ROOT_W-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
        n_rem   = ge ? diff[ROOT_W:0] : shifted[ROOT_W:0];
        n_root  = {r_root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

>>> sv/atl_cordic.sv
// ----------------------------------------------------------------------------
// atl_cordic
// Iterative vectoring CORDIC, atan2 in Q.16 degrees, shared by both angles
// ----------------------------------------------------------------------------
module atl_cordic #(
    parameter int IN_W  = 22,
    parameter int STEPS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [IN_W-1:0]        i_x,
    input  logic signed [IN_W-1:0]        i_y,
    output logic                          o_busy,
    output logic signed [atl_pkg::ZW-1:0] o_z
);

    localparam int CW = IN_W + 18;

    logic signed [CW-1:0]          r_x;
    logic signed [CW-1:0]          r_y;
    logic signed [atl_pkg::ZW-1:0] r_z;
    logic [atl_pkg::STEP_W-1:0]    r_cnt;
    logic                          r_busy;

    logic signed [CW-1:0]          xe;
    logic signed [CW-1:0]          ye;
    logic signed [CW-1:0]          x0;
    logic signed [CW-1:0]          y0;
    logic signed [atl_pkg::ZW-1:0] z0;
    logic                          s_done;

    logic signed [CW-1:0]          xs;
    logic signed [CW-1:0]          ys;
    logic signed [atl_pkg::ZW-1:0] ang;
    logic signed [CW-1:0]          n_x;
    logic signed [CW-1:0]          n_y;
    logic signed [atl_pkg::ZW-1:0] n_z;

    // start values and axis cases
    always_comb begin
        xe     = CW'(i_x);
        ye     = CW'(i_y);
        x0     = xe <<< atl_pkg::DEG_FRAC;
        y0     = ye <<< atl_pkg::DEG_FRAC;
        z0     = '0;
        s_done = 1'b0;
        if (i_y == '0) begin
            s_done = 1'b1;
            z0     = i_x[IN_W-1] ? atl_pkg::Z_180 : '0;
        end else if (i_x == '0) begin
            s_done = 1'b1;
            z0     = i_y[IN_W-1] ? -atl_pkg::Z_90 : atl_pkg::Z_90;
        end else if (i_x[IN_W-1]) begin
            x0 = (-xe) <<< atl_pkg::DEG_FRAC;
            y0 = (-ye) <<< atl_pkg::DEG_FRAC;
            z0 = i_y[IN_W-1] ? -atl_pkg::Z_180 : atl_pkg::Z_180;
        end
    end

    // one micro-rotation
    always_comb begin
        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;
        ang = atl_pkg::ZW'(atl_pkg::ATAN_TAB[r_cnt]);
        if (r_y[CW-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !s_done;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == atl_pkg::STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= x0;
            r_y <= y0;
            r_z <= z0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_busy = r_busy;
    assign o_z    = r_z;

endmodule

>>> sv/accel_tilt_lowpass_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_lowpass_core
// Accelerometer scaling, moving-average filter and roll/pitch via CORDIC
// ----------------------------------------------------------------------------
// Input channel: i_in_valid/o_in_ready carry one raw three-axis sample per
// transaction. Output channel: o_out_valid/i_out_ready carry roll, pitch and
// the three filtered axes per transaction, one result per sample.
// When the pitch needs no rotation (filtered x zero, or filtered y and z both
// zero) the pitch CORDIC pass is skipped. The time per sample is set by the
// shared multiplier (three filter products, two squares), the bit-serial
// square root, which runs alongside the roll CORDIC pass, and the pitch
// CORDIC pass on the same rotation unit.
// The block takes one sample at a time. A finished result sits in the output
// register; the next sample is accepted while it waits, and the block holds
// its following result until the receiver takes the earlier one.
// Reset clears the filter state, sets alpha to 51 and range code to 0.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module accel_tilt_lowpass_core #(
    parameter int RAW_BITS     = 10,
    parameter int ALPHA_BITS   = 8,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [atl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ALPHA_BITS:0]                  i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [RAW_BITS-1:0]           i_raw_x,
    input  logic signed [RAW_BITS-1:0]           i_raw_y,
    input  logic signed [RAW_BITS-1:0]           i_raw_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [atl_pkg::ROLL_W-1:0]    o_roll_deg,
    output logic signed [atl_pkg::PITCH_W-1:0]   o_pitch_deg,
    output logic signed [RAW_BITS+2:0]           o_filt_x,
    output logic signed [RAW_BITS+2:0]           o_filt_y,
    output logic signed [RAW_BITS+2:0]           o_filt_z
);

    localparam int FB       = RAW_BITS + 3;
    localparam int CFG_W    = ALPHA_BITS + 1;
    localparam int MUL_W    = (FB + 1 > ALPHA_BITS + 2) ? FB + 1 : ALPHA_BITS + 2;
    localparam int ROOT_W   = FB + 8;
    localparam int ANG_W    = FB + 9;
    localparam int SUM_W    = 2 * FB;
    localparam int SQ_W     = 2 * FB - 1;
    localparam int PITCH_SH = 8;

    localparam logic [CFG_W-1:0] ALPHA_ONE   = CFG_W'(1) << ALPHA_BITS;
    localparam logic [CFG_W-1:0] ALPHA_RESET = CFG_W'(51);

    localparam logic [2:0] ST_DX  = 3'd0;
    localparam logic [2:0] ST_DY  = 3'd1;
    localparam logic [2:0] ST_DZ  = 3'd2;
    localparam logic [2:0] ST_SQY = 3'd3;
    localparam logic [2:0] ST_SQZ = 3'd4;
    localparam logic [2:0] ST_SUM = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_ROLL  = 4'b0100,
        S_PITCH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_step, n_step;

    logic [CFG_W-1:0] r_alpha;
    logic [1:0]       r_range;

    logic signed [FB-1:0] r_ax, r_ay, r_az;
    logic signed [FB-1:0] r_fx, r_fy, r_fz;
    logic signed [2*MUL_W-1:0] r_prod;
    logic [SQ_W-1:0] r_sqy;
    logic signed [atl_pkg::DEG_W-1:0] r_roll;

    logic                               r_out_valid;
    logic signed [atl_pkg::ROLL_W-1:0]  r_o_roll;
    logic signed [atl_pkg::PITCH_W-1:0] r_o_pitch;
    logic signed [FB-1:0]               r_o_fx, r_o_fy, r_o_fz;

    logic [CFG_W-1:0]     w;
    logic signed [FB-1:0] sx, sy, sz;
    logic signed [MUL_W-1:0] ma, mb;
    logic signed [FB-1:0] delta;
    logic [SUM_W-1:0]     sumsq;
    logic [2*ROOT_W-1:0]  rad;

    logic                 accept;
    logic                 mul_last;
    logic                 units_idle;
    logic                 out_free;
    logic                 load;

    logic                 cordic_start;
    logic                 cordic_busy;
    logic signed [ANG_W-1:0] cx, cy, negx;
    logic signed [atl_pkg::ZW-1:0] cordic_z;
    logic                 sqrt_busy;
    logic [ROOT_W-1:0]    root;
    logic signed [atl_pkg::DEG_W-1:0] roll_deg;
    logic signed [atl_pkg::DEG_W-1:0] pitch_deg;

    atl_cordic #(
        .IN_W  (ANG_W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (cx),
        .i_y     (cy),
        .o_busy  (cordic_busy),
        .o_z     (cordic_z)
    );

    atl_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_last),
        .i_rad   (rad),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    assign w  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign sx = FB'(i_raw_x) <<< r_range;
    assign sy = FB'(i_raw_y) <<< r_range;
    assign sz = FB'(i_raw_z) <<< r_range;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign mul_last   = (r_state == S_MUL) && (r_step == ST_SUM);
    assign units_idle = !cordic_busy && !sqrt_busy;
    assign out_free   = !r_out_valid || i_out_ready;
    assign load       = (r_state == S_PITCH) && !cordic_busy && out_free;

    // shared multiplier operands
    always_comb begin
        case (r_step)
            ST_DX: begin
                ma = MUL_W'(r_ax) - MUL_W'(r_fx);
                mb = MUL_W'(w);
            end
            ST_DY: begin
                ma = MUL_W'(r_ay) - MUL_W'(r_fy);
                mb = MUL_W'(w);
            end
            ST_DZ: begin
                ma = MUL_W'(r_az) - MUL_W'(r_fz);
                mb = MUL_W'(w);
            end
            ST_SQY: begin
                ma = MUL_W'(r_fy);
                mb = MUL_W'(r_fy);
            end
            ST_SQZ: begin
                ma = MUL_W'(r_fz);
                mb = MUL_W'(r_fz);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign delta = r_prod[ALPHA_BITS +: FB];
    assign sumsq = SUM_W'(r_sqy) + SUM_W'(r_prod[SQ_W-1:0]);
    assign rad   = {sumsq, 16'b0};

    // angle unit operands: roll first, then pitch
    assign negx = -ANG_W'(r_fx);
    always_comb begin
        if (r_state == S_MUL) begin
            cx = ANG_W'(r_fz);
            cy = ANG_W'(r_fy);
        end else begin
            cx = ANG_W'(root);
            cy = negx <<< PITCH_SH;
        end
    end

    assign cordic_start = mul_last || ((r_state == S_ROLL) && units_idle);
    assign roll_deg     = atl_pkg::whole_deg(cordic_z, atl_pkg::ROLL_LIM);
    assign pitch_deg    = atl_pkg::whole_deg(cordic_z, atl_pkg::PITCH_LIM);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                    n_step  = ST_DX;
                end
            end
            S_MUL: begin
                n_step = r_step + 3'd1;
                if (r_step == ST_SUM) begin
                    n_state = S_ROLL;
                end
            end
            S_ROLL: begin
                if (units_idle) begin
                    n_state = S_PITCH;
                end
            end
            S_PITCH: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_DX;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_range <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                atl_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                atl_pkg::REG_RANGE: r_range <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0;
            r_fy <= '0;
            r_fz <= '0;
        end else if (r_state == S_MUL) begin
            case (r_step)
                ST_DY:   r_fx <= r_fx + delta;
                ST_DZ:   r_fy <= r_fy + delta;
                ST_SQY:  r_fz <= r_fz + delta;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax <= sx;
            r_ay <= sy;
            r_az <= sz;
        end
        r_prod <= ma * mb;
        if ((r_state == S_MUL) && (r_step == ST_SQZ)) begin
            r_sqy <= r_prod[SQ_W-1:0];
        end
        if ((r_state == S_ROLL) && units_idle) begin
            r_roll <= roll_deg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_roll  <= r_roll[atl_pkg::ROLL_W-1:0];
            r_o_pitch <= pitch_deg[atl_pkg::PITCH_W-1:0];
            r_o_fx    <= r_fx;
            r_o_fy    <= r_fy;
            r_o_fz    <= r_fz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_roll_deg  = r_o_roll;
    assign o_pitch_deg = r_o_pitch;
    assign o_filt_x    = r_o_fx;
    assign o_filt_y    = r_o_fy;
    assign o_filt_z    = r_o_fz;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerometer tilt low-pass core
// ----------------------------------------------------------------------------
// Raw three-axis samples go in through a queue-fed driver. Roll, pitch and the
// filtered axes of every result are checked against an in-bench fixed-point
// model of the scaling, the exponential moving average and the CORDIC angle
// step. The run walks through several alpha and range settings, the clamped
// and frozen filter cases among them, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int  RAW_W    = 10;
    localparam int  FILT_W   = RAW_W + 3;
    localparam int  ALPHA_W  = 9;
    localparam int  ANG_STEPS = 14;
    localparam longint DEG_ONE = 65536;
    localparam longint ALPHA_ONE = 256;
    localparam int  IDLE_LIMIT = 3000;
    localparam int  TAIL_CYCLES = 60;

    localparam longint ATAN_Q16 [0:19] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [RAW_W-1:0] x;
        logic signed [RAW_W-1:0] y;
        logic signed [RAW_W-1:0] z;
    } accel_sample_t;

    typedef struct packed {
        logic signed [atl_pkg::ROLL_W-1:0]  roll;
        logic signed [atl_pkg::PITCH_W-1:0] pitch;
        logic signed [FILT_W-1:0]           fx;
        logic signed [FILT_W-1:0]           fy;
        logic signed [FILT_W-1:0]           fz;
    } tilt_t;

    logic                              i_clk;
    logic                              i_rst_n    = 1'b0;
    logic                              i_cfg_we   = 1'b0;
    logic [atl_pkg::CFG_IDX_W-1:0]     i_cfg_idx  = atl_pkg::REG_ALPHA;
    logic [ALPHA_W-1:0]                i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic signed [RAW_W-1:0]           i_raw_x    = '0;
    logic signed [RAW_W-1:0]           i_raw_y    = '0;
    logic signed [RAW_W-1:0]           i_raw_z    = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [atl_pkg::ROLL_W-1:0] o_roll_deg;
    logic signed [atl_pkg::PITCH_W-1:0] o_pitch_deg;
    logic signed [FILT_W-1:0]          o_filt_x;
    logic signed [FILT_W-1:0]          o_filt_y;
    logic signed [FILT_W-1:0]          o_filt_z;

    accel_sample_t raw_pending [$];
    tilt_t         tilt_expected [$];

    // model copy of the registers and filter state
    longint unsigned cfg_alpha = 51;
    longint unsigned cfg_range = 0;
    longint avg_x = 0;
    longint avg_y = 0;
    longint avg_z = 0;

    int  n_issued   = 0;
    int  n_results  = 0;
    int  n_errors   = 0;
    int  n_settings = 0;
    int  idle_cycles = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    bit  in_fire  = 1'b0;
    bit  out_fire = 1'b0;
    bit  out_seen = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    accel_tilt_lowpass_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_raw_z     (i_raw_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_roll_deg  (o_roll_deg),
        .o_pitch_deg (o_pitch_deg),
        .o_filt_x    (o_filt_x),
        .o_filt_y    (o_filt_y),
        .o_filt_z    (o_filt_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint ema_step(longint avg, longint a, longint w);
        return (a * w + avg * (ALPHA_ONE - w)) >>> 8;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // atan2 in degrees Q.16
    function automatic longint atan2_q16(longint y, longint x);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (y == 0)
            return (x >= 0) ? 0 : 180 * DEG_ONE;
        if (x == 0)
            return (y > 0) ? 90 * DEG_ONE : -90 * DEG_ONE;
        if (x < 0) begin
            ang = (y > 0) ? 180 * DEG_ONE : -180 * DEG_ONE;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < ANG_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - ATAN_Q16[i];
            end else begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + ATAN_Q16[i];
            end
        end
        return ang;
    endfunction

    function automatic longint trunc_deg(longint ang, longint lim);
        longint d;
        d = (ang >= 0) ? (ang >>> 16) : -((-ang) >>> 16);
        if (d > lim)
            d = lim;
        if (d < -lim)
            d = -lim;
        return d;
    endfunction

    function automatic tilt_t tilt_from_sample(accel_sample_t s);
        tilt_t  t;
        longint w;
        longint r;
        longint sumsq;
        w = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : longint'(cfg_alpha);
        avg_x = ema_step(avg_x, longint'(s.x) * (longint'(1) << cfg_range), w);
        avg_y = ema_step(avg_y, longint'(s.y) * (longint'(1) << cfg_range), w);
        avg_z = ema_step(avg_z, longint'(s.z) * (longint'(1) << cfg_range), w);
        sumsq = avg_y * avg_y + avg_z * avg_z;
        r = floor_sqrt(longint'(unsigned'(sumsq)) << 16);
        t.roll  = atl_pkg::ROLL_W'(trunc_deg(atan2_q16(avg_y, avg_z), 180));
        t.pitch = atl_pkg::PITCH_W'(trunc_deg(atan2_q16(-avg_x * 256, r), 90));
        t.fx = FILT_W'(avg_x);
        t.fy = FILT_W'(avg_y);
        t.fz = FILT_W'(avg_z);
        return t;
    endfunction

    // input and output transactions, prediction and checking
    always @(posedge i_clk) begin
        tilt_t want;
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
            out_seen <= 1'b0;
        end else begin
            in_fire  <= i_in_valid && o_in_ready;
            out_fire <= o_out_valid && i_out_ready;
            out_seen <= o_out_valid;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (i_in_valid && o_in_ready)
                tilt_expected.push_back(tilt_from_sample('{i_raw_x, i_raw_y, i_raw_z}));
            if (o_out_valid && i_out_ready) begin
                n_results = n_results + 1;
                if (tilt_expected.size() == 0) begin
                    $error("result transaction with no sample outstanding");
                    n_errors = n_errors + 1;
                end else begin
                    want = tilt_expected.pop_front();
                    if (o_roll_deg !== want.roll) begin
                        $error("roll_deg expected %0d actual %0d", want.roll, o_roll_deg);
                        n_errors = n_errors + 1;
                    end
                    if (o_pitch_deg !== want.pitch) begin
                        $error("pitch_deg expected %0d actual %0d", want.pitch, o_pitch_deg);
                        n_errors = n_errors + 1;
                    end
                    if (o_filt_x !== want.fx) begin
                        $error("filt_x expected %0d actual %0d", want.fx, o_filt_x);
                        n_errors = n_errors + 1;
                    end
                    if (o_filt_y !== want.fy) begin
                        $error("filt_y expected %0d actual %0d", want.fy, o_filt_y);
                        n_errors = n_errors + 1;
                    end
                    if (o_filt_z !== want.fz) begin
                        $error("filt_z expected %0d actual %0d", want.fz, o_filt_z);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        accel_sample_t s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (raw_pending.size() != 0) begin
                s = raw_pending.pop_front();
                i_raw_x    <= s.x;
                i_raw_y    <= s.y;
                i_raw_z    <= s.z;
                i_in_valid <= 1'b1;
                gap_left   <= tx_gaps ? $urandom_range(0, 10) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, stall counted while a result waits
    always @(negedge i_clk) begin
        int s;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (out_fire) begin
            s = rx_gaps ? $urandom_range(0, 10) : 0;
            stall_left  <= s;
            i_out_ready <= (s == 0);
        end else if (stall_left != 0) begin
            if (out_seen) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= (stall_left == 1);
            end
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_sample(input int x, input int y, input int z);
        accel_sample_t s;
        s.x = RAW_W'(x);
        s.y = RAW_W'(y);
        s.z = RAW_W'(z);
        raw_pending.push_back(s);
        n_issued = n_issued + 1;
    endtask

    task automatic write_reg(input logic [atl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ALPHA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == atl_pkg::REG_ALPHA)
            cfg_alpha = 64'(val);
        else
            cfg_range = 64'(val & 9'd3);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_results != n_issued)
            @(negedge i_clk);
    endtask

    function automatic int clamp_raw(int v);
        return (v > 511) ? 511 : ((v < -512) ? -512 : v);
    endfunction

    function automatic int pick_axis();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return $urandom_range(0, 1) ? 511 : -512;
            default: return int'($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    // most often a held orientation, some with jitter, the rest noise and extremes
    task automatic queue_random(input int count);
        int bx, by, bz, sel;
        bx = 0;
        by = 0;
        bz = 0;
        for (int k = 0; k < count; k++) begin
            if (k % 20 == 0 || $urandom_range(0, 24) == 0) begin
                bx = pick_axis();
                by = pick_axis();
                bz = pick_axis();
            end
            sel = $urandom_range(0, 9);
            if (sel < 4)
                queue_sample(bx, by, bz);
            else if (sel < 7)
                queue_sample(clamp_raw(bx + int'($urandom_range(0, 16)) - 8),
                             clamp_raw(by + int'($urandom_range(0, 16)) - 8),
                             clamp_raw(bz + int'($urandom_range(0, 16)) - 8));
            else if (sel < 9)
                queue_sample(int'($urandom_range(0, 1023)) - 512,
                             int'($urandom_range(0, 1023)) - 512,
                             int'($urandom_range(0, 1023)) - 512);
            else
                queue_sample(pick_axis(), pick_axis(), pick_axis());
        end
    endtask

    task automatic run_phase(input logic [ALPHA_W-1:0] alpha_val, input int range_val,
                             input bit tx_on, input bit rx_on, input int count);
        write_reg(atl_pkg::REG_ALPHA, alpha_val);
        write_reg(atl_pkg::REG_RANGE, ALPHA_W'(range_val | ($urandom_range(0, 127) << 2)));
        n_settings = n_settings + 1;
        @(posedge i_clk);
        tx_gaps = tx_on;
        rx_gaps = rx_on;
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        @(posedge i_clk);
        n_settings = 1;
        queue_sample(511, 511, 511);
        queue_sample(-512, -512, -512);
        queue_sample(100, -200, 300);
        queue_sample(0, 0, 0);
        wait_drained();

        // no filtering: each result follows its own sample
        write_reg(atl_pkg::REG_ALPHA, 9'd256);
        write_reg(atl_pkg::REG_RANGE, 9'd0);
        n_settings = n_settings + 1;
        @(posedge i_clk);
        queue_sample(0, 0, 0);
        queue_sample(0, 0, -100);
        queue_sample(0, 100, 0);
        queue_sample(0, -100, 0);
        queue_sample(100, 0, 0);
        queue_sample(-100, 0, 0);
        queue_sample(0, 50, -200);
        queue_sample(0, -50, -200);
        queue_sample(0, 1, -511);
        queue_sample(0, -1, -511);
        queue_sample(511, 511, 511);
        queue_sample(-512, -512, -512);
        queue_sample(-512, 511, -512);
        queue_sample(511, -512, 511);
        queue_sample(1, -1, 1);
        queue_sample(300, -400, 50);
        wait_drained();

        // widest range reaches the ends of the filtered fields
        write_reg(atl_pkg::REG_RANGE, 9'd3);
        n_settings = n_settings + 1;
        @(posedge i_clk);
        queue_sample(511, -512, 511);
        queue_sample(-512, 511, -512);
        wait_drained();

        // alpha above one acts as one
        write_reg(atl_pkg::REG_ALPHA, 9'd300);
        n_settings = n_settings + 1;
        @(posedge i_clk);
        queue_sample(200, -300, 400);
        queue_sample(-5, 7, -9);
        wait_drained();

        run_phase(9'd51,  1, 1'b1, 1'b1, 100);
        run_phase(9'd0,   2, 1'b1, 1'b1, 30);
        run_phase(9'd256, 3, 1'b0, 1'b0, 100);
        run_phase(9'd511, 0, 1'b1, 1'b1, 100);
        run_phase(9'd1,   1, 1'b1, 1'b0, 100);
        run_phase(9'd128, 2, 1'b0, 1'b1, 100);
        run_phase(9'd200, 3, 1'b1, 1'b1, 100);
        run_phase(9'd32,  0, 1'b1, 1'b0, 100);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tilt_expected.size() != 0) begin
            $error("%0d expected results never arrived", tilt_expected.size());
            n_errors = n_errors + 1;
        end
        $display("checked %0d tilt results over %0d alpha/range settings, %0d mismatches",
                 n_results, n_settings, n_errors);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
sv/atl_pkg.sv
sv/atl_sqrt.sv
sv/atl_cordic.sv
sv/accel_tilt_lowpass_core.sv
tb/tb.sv
